/* design/interrupt_deadtime_tracker_defines.svh */
// assertion macros used by the interrupt dead-time tracker checker
`ifndef INTERRUPT_DEADTIME_TRACKER_DEFINES_SVH
`define INTERRUPT_DEADTIME_TRACKER_DEFINES_SVH

// clocked check, muted while reset is asserted
`define IDT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// clocked check that also holds during reset
`define IDT_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: reset check failed");

`endif

/* design/idt_pkg.sv */
// shared types, codes and helpers of the interrupt dead-time tracker
package idt_pkg;

	localparam int unsigned TimerW   = 16;
	localparam int unsigned IvalW    = 24;
	localparam int unsigned CountW   = 32;
	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 104;

	localparam logic [CfgIdxW-1:0] REG_ACK_LATENCY   = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_SERVICE_CYCLE = 8'd1;

	localparam logic [TimerW-1:0] ACK_LATENCY_RST   = 16'd32;
	localparam logic [TimerW-1:0] SERVICE_CYCLE_RST = 16'd70;

	localparam logic [1:0] OUT_DETECTED     = 2'd0;
	localparam logic [1:0] OUT_LOST_ACK     = 2'd1;
	localparam logic [1:0] OUT_PENDING      = 2'd2;
	localparam logic [1:0] OUT_REJ_PENDING  = 2'd3;

	typedef struct packed {
		logic [TimerW-1:0] ack_left;
		logic [TimerW-1:0] service_left;
		logic              pending;
	} timer_state_t;

	typedef struct packed {
		timer_state_t nxt;
		logic [1:0]   outcome;
		logic         retrig;
		logic [1:0]   det_inc;
		logic         rej_inc;
	} judge_t;

	function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
			input logic [1:0] b);
		logic [CountW:0] s;
		s = {1'b0, a} + {{(CountW-1){1'b0}}, b};
		return s[CountW] ? {CountW{1'b1}} : s[CountW-1:0];
	endfunction

endpackage

/* design/interrupt_deadtime_tracker.sv */
// interrupt dead-time tracker top level
//
// pulses arrive on the s_ stream: s_tdata[23:0] is the tick count since the
// previous pulse. every pulse gives exactly one result on the m_ stream with
// the outcome, retrigger flag, pending flag and the three running counters.
// index 0 selects ack_latency and index 1 service_cycle; both registers are
// written through the cfg_ channel, one transfer per write, always ready;
// unknown indexes are dropped. write them only while no pulse is in flight.
// the input register loads at the input transfer, and the judgement logic
// fills the result register from it when the result register is empty or
// being taken; m_tvalid rises as the result register loads.
// throughput: one pulse per cycle while the receiver does not stall; the
// timer and counter update is combinational between the input register and
// the result register.
// when the receiver stalls the result register holds, the input register
// still fills, and s_tready drops once both are occupied.
// reset clears the timers, the pending flag and the counters, empties both
// registers and restores the register defaults 32 and 70.
module interrupt_deadtime_tracker import idt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // [23:0] interval_ticks
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // [1:0] outcome, [2] retriggered,
	                                       // [3] pending, [35:4] event_total,
	                                       // [67:36] detected_total,
	                                       // [99:68] rejected_total, [103:100] zero
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [TimerW-1:0]   cfg_data
);

	logic [TimerW-1:0]   ack_latency;
	logic [TimerW-1:0]   service_cycle;
	logic                valid_s1;
	logic [IvalW-1:0]    interval_s1;
	timer_state_t        state_q;
	logic [CountW-1:0]   event_q;
	logic [CountW-1:0]   detected_q;
	logic [CountW-1:0]   rejected_q;
	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;
	logic                advance;
	judge_t              judge;
	logic [CountW-1:0]   event_nxt;
	logic [CountW-1:0]   detected_nxt;
	logic [CountW-1:0]   rejected_nxt;

	idt_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.ack_latency   (ack_latency),
		.service_cycle (service_cycle)
	);

	idt_judge u_judge (
		.cur           (state_q),
		.interval      (interval_s1),
		.ack_latency   (ack_latency),
		.service_cycle (service_cycle),
		.res           (judge)
	);

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign event_nxt    = sat_add(event_q, 2'd1);
	assign detected_nxt = sat_add(detected_q, judge.det_inc);
	assign rejected_nxt = sat_add(rejected_q, {1'b0, judge.rej_inc});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			interval_s1 <= s_tdata[IvalW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			event_q     <= '0;
			detected_q  <= '0;
			rejected_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= judge.nxt;
				event_q     <= event_nxt;
				detected_q  <= detected_nxt;
				rejected_q  <= rejected_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0, rejected_nxt, detected_nxt, event_nxt,
				judge.nxt.pending, judge.retrig, judge.outcome};
		end
	end

endmodule

/* design/idt_cfg.sv */
// configuration registers for acknowledge latency and service cycle
module idt_cfg import idt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [TimerW-1:0]  cfg_data,
	output logic [TimerW-1:0]  ack_latency,
	output logic [TimerW-1:0]  service_cycle
);

	logic [TimerW-1:0] ack_latency_q;
	logic [TimerW-1:0] service_cycle_q;

	assign cfg_ready     = 1'b1;
	assign ack_latency   = ack_latency_q;
	assign service_cycle = service_cycle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_latency_q   <= ACK_LATENCY_RST;
			service_cycle_q <= SERVICE_CYCLE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACK_LATENCY:   ack_latency_q   <= cfg_data;
				REG_SERVICE_CYCLE: service_cycle_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* design/idt_judge.sv */
// per-pulse judgement: timers, pending flag, outcome and counter steps
module idt_judge import idt_pkg::*; (
	input  timer_state_t      cur,
	input  logic [IvalW-1:0]  interval,
	input  logic [TimerW-1:0] ack_latency,
	input  logic [TimerW-1:0] service_cycle,
	output judge_t            res
);

	logic              lost0;
	logic              defer0;
	logic              retrig;
	logic              lost1;
	logic              defer1;
	logic [TimerW:0]   window;
	logic [IvalW-1:0]  e_rem;
	logic [TimerW-1:0] e2;

	assign lost0  = (cur.ack_left != '0) && (interval < {8'b0, cur.ack_left});
	assign defer0 = !lost0 && (cur.service_left != '0) &&
		(interval < {8'b0, cur.service_left});
	assign window = {1'b0, cur.service_left} + {1'b0, service_cycle};
	assign retrig = !lost0 && !defer0 && (cur.service_left != '0) &&
		(interval < {7'b0, window});
	assign e_rem  = interval - {8'b0, cur.service_left};
	assign e2     = e_rem[TimerW-1:0];
	assign lost1  = (ack_latency != '0) && (e2 < ack_latency);
	assign defer1 = !lost1 && (service_cycle != '0) && (e2 < service_cycle);

	always_comb begin
		res.nxt.ack_left     = ack_latency;
		res.nxt.service_left = service_cycle;
		res.nxt.pending      = 1'b0;
		res.outcome          = OUT_DETECTED;
		res.retrig           = retrig;
		res.det_inc          = {1'b0, 1'b1} + {1'b0, cur.pending};
		res.rej_inc          = 1'b0;
		if (lost0) begin
			res.nxt.ack_left     = cur.ack_left - interval[TimerW-1:0];
			res.nxt.service_left = (interval >= {8'b0, cur.service_left}) ? '0 :
				cur.service_left - interval[TimerW-1:0];
			res.nxt.pending      = cur.pending;
			res.outcome          = OUT_LOST_ACK;
			res.det_inc          = 2'd0;
			res.rej_inc          = 1'b1;
		end else if (defer0 || (retrig && defer1)) begin
			res.nxt.ack_left     = '0;
			res.nxt.service_left = defer0 ? cur.service_left - interval[TimerW-1:0] :
				service_cycle - e2;
			res.nxt.pending      = 1'b1;
			res.det_inc          = 2'd0;
			res.outcome          = cur.pending ? OUT_REJ_PENDING : OUT_PENDING;
			res.rej_inc          = cur.pending;
		end else if (retrig && lost1) begin
			res.nxt.ack_left     = ack_latency - e2;
			res.nxt.service_left = (e2 >= service_cycle) ? '0 : service_cycle - e2;
			res.nxt.pending      = cur.pending;
			res.outcome          = OUT_LOST_ACK;
			res.det_inc          = 2'd0;
			res.rej_inc          = 1'b1;
		end
	end

endmodule

/* design/idt_checker.sv */
// port-level checks for the interrupt dead-time tracker, bound to the top level
`include "interrupt_deadtime_tracker_defines.svh"

module idt_checker import idt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	logic [1:0] outcome;
	logic       pend;
	logic       latched;

	assign outcome = m_tdata[1:0];
	assign pend    = m_tdata[3];
	assign latched = (outcome == OUT_PENDING) || (outcome == OUT_REJ_PENDING);

	`IDT_ASSERT_RST(a_reset_empty, !arst_n |-> !m_tvalid)
	`IDT_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	`IDT_ASSERT(a_pending_consistent, m_tvalid && latched |-> pend)
	`IDT_ASSERT(a_detect_clears, m_tvalid && outcome == OUT_DETECTED |-> !pend)
	`IDT_ASSERT(a_event_counted, m_tvalid |-> m_tdata[35:4] != 32'd0)

endmodule

bind interrupt_deadtime_tracker idt_checker u_idt_checker (.*);
